>>> hdl/wsd_pkg.sv
// Shared types and constants for the frame deframer.
package wsd_pkg;

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_EXT16  = 3'd2;
  localparam logic [2:0] PH_EXT64  = 3'd3;
  localparam logic [2:0] PH_KEY    = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_CLOSED = 3'd6;
  localparam logic [2:0] PH_ERROR  = 3'd7;

  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_BADOP  = 3'd2;
  localparam logic [2:0] ST_CLOSE  = 3'd3;
  localparam logic [2:0] ST_TOOBIG = 3'd4;

  localparam logic [1:0] KIND_TEXT   = 2'd0;
  localparam logic [1:0] KIND_BINARY = 2'd1;
  localparam logic [1:0] KIND_PING   = 2'd2;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [31:0] MAX_LEN_RESET = 32'd2048;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [1:0] frame_kind;
    logic       last;
    logic [2:0] status;
  } result_t;

endpackage

>>> hdl/wsd_parser.sv
// Header parser and payload unmasking, one byte per accepted item.
module wsd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  output logic              res_valid,
  output wsd_pkg::result_t  res
);

  logic [2:0]  phase, phase_next;
  logic [3:0]  hcount, hcount_next;
  logic [1:0]  kind, kind_next;
  logic        mask, mask_next;
  logic [31:0] accum, accum_next;
  logic [31:0] remain, remain_next;
  logic [31:0] key, key_next;
  logic [1:0]  lane, lane_next;
  logic [31:0] max_len;
  logic        len_done;
  logic        hdr_done;
  logic        lastf;
  logic [7:0]  key_byte;

  always_comb begin
    case (lane)
      2'd0: key_byte = key[31:24];
      2'd1: key_byte = key[23:16];
      2'd2: key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  always_comb begin
    phase_next  = phase;
    hcount_next = hcount;
    kind_next   = kind;
    mask_next   = mask;
    accum_next  = accum;
    remain_next = remain;
    key_next    = key;
    lane_next   = lane;
    len_done    = 1'b0;
    hdr_done    = 1'b0;
    lastf       = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    if (in_fire) begin
      case (phase)
        wsd_pkg::PH_HDR0: begin
          phase_next = wsd_pkg::PH_HDR1;
          if (!in_byte[7]) begin
            phase_next = wsd_pkg::PH_ERROR;
            res_valid  = 1'b1;
            res.status = wsd_pkg::ST_BADOP;
          end else begin
            case (in_byte[3:0])
              wsd_pkg::OP_TEXT:   kind_next = wsd_pkg::KIND_TEXT;
              wsd_pkg::OP_BINARY: kind_next = wsd_pkg::KIND_BINARY;
              wsd_pkg::OP_PING:   kind_next = wsd_pkg::KIND_PING;
              wsd_pkg::OP_CLOSE: begin
                phase_next = wsd_pkg::PH_CLOSED;
                res_valid  = 1'b1;
                res.status = wsd_pkg::ST_CLOSE;
              end
              default: begin
                phase_next = wsd_pkg::PH_ERROR;
                res_valid  = 1'b1;
                res.status = wsd_pkg::ST_BADOP;
              end
            endcase
          end
        end
        wsd_pkg::PH_HDR1: begin
          mask_next   = in_byte[7];
          hcount_next = '0;
          accum_next  = '0;
          if (in_byte[6:0] == wsd_pkg::LEN_EXT16) begin
            phase_next = wsd_pkg::PH_EXT16;
          end else if (in_byte[6:0] == wsd_pkg::LEN_EXT64) begin
            phase_next = wsd_pkg::PH_EXT64;
          end else begin
            accum_next = {25'd0, in_byte[6:0]};
            len_done   = 1'b1;
          end
        end
        wsd_pkg::PH_EXT16: begin
          accum_next  = {accum[23:0], in_byte};
          hcount_next = hcount + 4'd1;
          len_done    = (hcount_next >= 4'd2);
        end
        wsd_pkg::PH_EXT64: begin
          if (hcount < 4'd4 && in_byte != 8'd0) begin
            phase_next = wsd_pkg::PH_ERROR;
            res_valid  = 1'b1;
            res.status = wsd_pkg::ST_TOOBIG;
          end else begin
            accum_next  = {accum[23:0], in_byte};
            hcount_next = hcount + 4'd1;
            len_done    = (hcount_next >= 4'd8);
          end
        end
        wsd_pkg::PH_KEY: begin
          key_next    = {key[23:0], in_byte};
          hcount_next = hcount + 4'd1;
          hdr_done    = (hcount_next >= 4'd4);
        end
        wsd_pkg::PH_DATA: begin
          lastf       = (remain <= 32'd1);
          lane_next   = lastf ? 2'd0 : lane + 2'd1;
          remain_next = lastf ? 32'd0 : remain - 32'd1;
          if (lastf) begin
            phase_next = wsd_pkg::PH_HDR0;
          end
          res_valid        = 1'b1;
          res.payload_byte = in_byte ^ (mask ? key_byte : 8'd0);
          res.frame_kind   = kind;
          res.last         = lastf;
          res.status       = wsd_pkg::ST_DATA;
        end
        default: begin
        end
      endcase

      if (len_done) begin
        if (accum_next > max_len) begin
          phase_next = wsd_pkg::PH_ERROR;
          res_valid  = 1'b1;
          res.status = wsd_pkg::ST_TOOBIG;
        end else if (mask_next) begin
          hcount_next = '0;
          key_next    = '0;
          phase_next  = wsd_pkg::PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        lane_next   = '0;
        hcount_next = '0;
        if (accum_next == 32'd0) begin
          phase_next     = wsd_pkg::PH_HDR0;
          res_valid      = 1'b1;
          res.frame_kind = kind_next;
          res.last       = 1'b1;
          res.status     = wsd_pkg::ST_EMPTY;
        end else begin
          remain_next = accum_next;
          phase_next  = wsd_pkg::PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= wsd_pkg::PH_HDR0;
      hcount  <= '0;
      kind    <= '0;
      mask    <= 1'b0;
      accum   <= '0;
      remain  <= '0;
      key     <= '0;
      lane    <= '0;
      max_len <= wsd_pkg::MAX_LEN_RESET;
    end else begin
      phase  <= phase_next;
      hcount <= hcount_next;
      kind   <= kind_next;
      mask   <= mask_next;
      accum  <= accum_next;
      remain <= remain_next;
      key    <= key_next;
      lane   <= lane_next;
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
    end
  end

endmodule

>>> hdl/wsd_out_fifo.sv
// Two-entry result buffer that decouples the parser from the output stall.
module wsd_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  wsd_pkg::result_t  wr_data,
  output logic              has_room,
  output logic              rd_valid,
  input  logic              rd_ready,
  output wsd_pkg::result_t  rd_data
);

  wsd_pkg::result_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] level;
  logic       rd_fire;

  assign has_room = (level != 2'd2);
  assign rd_valid = (level != 2'd0);
  assign rd_data  = entry[rd_ptr];
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_fire})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

>>> hdl/websocket_frame_deframer.sv
// Top level of the frame deframer: input stream, parser and output buffer.
// The block takes one frame byte per item and can accept an item in every clock cycle; a
// byte that produces a result is written into the output buffer and shows on the output
// once older results are taken. Header bytes produce no result except on a fault, a close
// frame or an empty frame. Results pass through a two-entry output buffer, so the input
// keeps flowing while a result waits; the input stalls only when both entries are held.
// After a close frame or a fault the block drops every further byte until reset.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // max_payload_len
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // payload_byte
  output logic        m_axis_tlast,  // last
  output logic [4:0]  m_axis_tuser   // frame_kind [1:0], status [4:2]
);

  logic             in_fire;
  logic             res_valid;
  wsd_pkg::result_t res;
  wsd_pkg::result_t out_res;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .in_byte     (s_axis_tdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_valid),
    .wr_data  (res),
    .has_room (s_axis_tready),
    .rd_valid (m_axis_tvalid),
    .rd_ready (m_axis_tready),
    .rd_data  (out_res)
  );

  assign m_axis_tdata = out_res.payload_byte;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = {out_res.status, out_res.frame_kind};

  a_fault_result_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser[4:2] == wsd_pkg::ST_BADOP ||
      m_axis_tuser[4:2] == wsd_pkg::ST_CLOSE || m_axis_tuser[4:2] == wsd_pkg::ST_TOOBIG))
    |-> (!m_axis_tlast && m_axis_tdata == 8'd0 && m_axis_tuser[1:0] == 2'd0))
    else $error("Fault or close result carries data, kind or last.");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[4:2] == wsd_pkg::ST_EMPTY)
    |-> (m_axis_tlast && m_axis_tdata == 8'd0))
    else $error("Empty-frame result is not marked last or carries data.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("Input stalled while no result is pending.");

  a_result_needs_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !$past(m_axis_tvalid) && !$past(rst)) |-> $past(in_fire))
    else $error("Result appeared without an accepted item.");

endmodule

>>> bench/tb_websocket_frame_deframer.sv
// Self-checking testbench for websocket_frame_deframer with a built-in frame decoder model.
module tb_websocket_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 200;
  localparam int ENC_SHORT = 0;
  localparam int ENC_16 = 1;
  localparam int ENC_64 = 2;
  localparam int DRAIN_CYCLES = 4;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [4:0]  m_axis_tuser;

  // Decoder state kept by the testbench.
  logic [2:0]  dfr_phase = PH_HDR0;
  logic [3:0]  dfr_hdr_cnt = '0;
  logic [1:0]  dfr_kind = KIND_TEXT;
  logic        dfr_masked = 1'b0;
  logic [31:0] dfr_len = '0;
  logic [31:0] dfr_left = '0;
  logic [31:0] dfr_key = '0;
  logic [1:0]  dfr_lane = '0;
  logic [31:0] dfr_limit = MAX_LEN_RESET;

  result_t     due_results[$];
  result_t     want;
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  websocket_frame_deframer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit fault_result(input logic [2:0] ph, input logic [2:0] st,
                                      output result_t r);
    dfr_phase = ph;
    r = '{payload_byte: 8'h00, frame_kind: KIND_TEXT, last: 1'b0, status: st};
    return 1'b1;
  endfunction

  function automatic bit header_finish(output result_t r);
    r = '0;
    dfr_lane = '0;
    dfr_hdr_cnt = '0;
    if (dfr_len == 0) begin
      dfr_phase = PH_HDR0;
      r = '{payload_byte: 8'h00, frame_kind: dfr_kind, last: 1'b1, status: ST_EMPTY};
      return 1'b1;
    end
    dfr_left = dfr_len;
    dfr_phase = PH_DATA;
    return 1'b0;
  endfunction

  function automatic bit length_finish(output result_t r);
    r = '0;
    if (dfr_len > dfr_limit) return fault_result(PH_ERROR, ST_TOOBIG, r);
    if (dfr_masked) begin
      dfr_hdr_cnt = '0;
      dfr_key = '0;
      dfr_phase = PH_KEY;
      return 1'b0;
    end
    return header_finish(r);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [7:0] k;
    logic       lastf;
    r = '0;
    case (dfr_phase)
      PH_HDR0: begin
        if (!b[7]) return fault_result(PH_ERROR, ST_BADOP, r);
        case (b[3:0])
          OP_TEXT:   dfr_kind = KIND_TEXT;
          OP_BINARY: dfr_kind = KIND_BINARY;
          OP_PING:   dfr_kind = KIND_PING;
          OP_CLOSE:  return fault_result(PH_CLOSED, ST_CLOSE, r);
          default:   return fault_result(PH_ERROR, ST_BADOP, r);
        endcase
        dfr_phase = PH_HDR1;
        return 1'b0;
      end
      PH_HDR1: begin
        dfr_masked = b[7];
        dfr_len = '0;
        dfr_hdr_cnt = '0;
        if (b[6:0] == LEN_EXT16) begin
          dfr_phase = PH_EXT16;
          return 1'b0;
        end
        if (b[6:0] == LEN_EXT64) begin
          dfr_phase = PH_EXT64;
          return 1'b0;
        end
        dfr_len = {25'd0, b[6:0]};
        return length_finish(r);
      end
      PH_EXT16: begin
        dfr_len = {dfr_len[23:0], b};
        dfr_hdr_cnt = dfr_hdr_cnt + 1'b1;
        if (dfr_hdr_cnt >= 2) return length_finish(r);
        return 1'b0;
      end
      PH_EXT64: begin
        if (dfr_hdr_cnt < 4 && b != 8'h00) return fault_result(PH_ERROR, ST_TOOBIG, r);
        dfr_len = {dfr_len[23:0], b};
        dfr_hdr_cnt = dfr_hdr_cnt + 1'b1;
        if (dfr_hdr_cnt >= 8) return length_finish(r);
        return 1'b0;
      end
      PH_KEY: begin
        dfr_key = {dfr_key[23:0], b};
        dfr_hdr_cnt = dfr_hdr_cnt + 1'b1;
        if (dfr_hdr_cnt >= 4) return header_finish(r);
        return 1'b0;
      end
      PH_DATA: begin
        k = dfr_masked ? dfr_key[31 - 8 * dfr_lane -: 8] : 8'h00;
        dfr_lane = dfr_lane + 1'b1;
        lastf = (dfr_left <= 1);
        dfr_left = lastf ? 32'd0 : dfr_left - 1;
        if (lastf) begin
          dfr_phase = PH_HDR0;
          dfr_lane = '0;
        end
        r = '{payload_byte: b ^ k, frame_kind: dfr_kind, last: lastf, status: ST_DATA};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (deframe_byte(b, r)) due_results.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [3:0] op, input int unsigned len, input bit masked,
                            input int enc, input logic [31:0] key, input int fill);
    send_byte({1'b1, 3'($urandom), op});
    case (enc)
      ENC_SHORT: send_byte({masked, len[6:0]});
      ENC_16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN_EXT64});
        repeat (4) send_byte(8'h00);
        for (int i = 3; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    end
    for (int unsigned i = 0; i < len; i++) send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [31:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dfr_limit = value;
  endtask

  task automatic send_random_frame();
    int unsigned len;
    int unsigned roll;
    int          enc;
    logic [3:0]  op;
    case ($urandom_range(2))
      0:       op = OP_TEXT;
      1:       op = OP_BINARY;
      default: op = OP_PING;
    endcase
    roll = $urandom_range(99);
    if (roll < 70) len = $urandom_range(8);
    else if (roll < 95) len = $urandom_range(40, 9);
    else len = $urandom_range(300, 41);
    if (len > dfr_limit) len = dfr_limit;
    roll = $urandom_range(9);
    if (len >= 126) enc = (roll < 7) ? ENC_16 : ENC_64;
    else enc = (roll < 6) ? ENC_SHORT : (roll < 8) ? ENC_16 : ENC_64;
    send_frame(op, len, 1'($urandom), enc, $urandom, -1);
  endtask

  task automatic test_directed_frames();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_frame(OP_TEXT, 3, 1'b0, ENC_SHORT, 32'h0, 8'h00);
    send_frame(OP_BINARY, 6, 1'b1, ENC_SHORT, 32'hA1B2C3D4, 8'hFF);
    send_frame(OP_PING, 2, 1'b1, ENC_SHORT, 32'h5A5A0FF0, -1);
    send_frame(OP_TEXT, 0, 1'b0, ENC_SHORT, 32'h0, -1);
    send_frame(OP_BINARY, 0, 1'b1, ENC_SHORT, $urandom, -1);
    send_frame(OP_PING, 4, 1'b0, ENC_16, 32'h0, -1);
    send_frame(OP_BINARY, 1, 1'b1, ENC_64, $urandom, -1);
  endtask

  task automatic test_limit_edges();
    set_limit(32'd0);
    send_frame(OP_TEXT, 0, 1'b1, ENC_16, $urandom, -1);
    send_frame(OP_PING, 0, 1'b0, ENC_64, 32'h0, -1);
    set_limit(32'd5);
    send_frame(OP_BINARY, 5, 1'b1, ENC_64, $urandom, -1);
    set_limit(32'hFFFF_FFFF);
    send_frame(OP_TEXT, 3, 1'b0, ENC_64, 32'h0, -1);
  endtask

  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                     input logic [31:0] limit);
    int unsigned first;
    set_limit(limit);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    first = bytes_sent;
    while (bytes_sent - first < PHASE_BYTES) send_random_frame();
  endtask

  task automatic test_sticky_tail();
    logic [7:0]  b;
    int unsigned pos;
    case ($urandom_range(3))
      0: begin
        do b = 8'($urandom);
        while (b[7] && (b[3:0] == OP_TEXT || b[3:0] == OP_BINARY ||
                        b[3:0] == OP_PING || b[3:0] == OP_CLOSE));
        send_byte(b);
      end
      1: send_byte({1'b1, 3'($urandom), OP_CLOSE});
      2: begin
        send_byte({1'b1, 3'($urandom), OP_BINARY});
        send_byte({1'($urandom), LEN_EXT64});
        pos = $urandom_range(3);
        repeat (pos) send_byte(8'h00);
        send_byte(8'($urandom_range(255, 1)));
      end
      default: begin
        set_limit($urandom_range(100));
        pos = dfr_limit + 1 + $urandom_range(150);
        send_frame(OP_TEXT, pos, 1'($urandom), pos < 126 ? ENC_SHORT : ENC_16, $urandom, -1);
      end
    endcase
    repeat (20) send_byte(8'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $error("result with nothing pending: payload_byte %0h status %0d",
               m_axis_tdata, m_axis_tuser[4:2]);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (m_axis_tdata !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[1:0] !== want.frame_kind) begin
          $error("frame_kind: expected %0d, got %0d", want.frame_kind, m_axis_tuser[1:0]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser[4:2] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser[4:2]);
          fail_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_websocket_frame_deframer: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_limit_edges();
    test_random_traffic(0, 0, MAX_LEN_RESET);
    test_random_traffic(45, 0, 32'hFFFF_FFFF);
    test_random_traffic(0, 45, $urandom_range(64, 1));
    test_random_traffic(37, 37, $urandom_range(20));
    test_sticky_tail();
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_websocket_frame_deframer: done, clean");
    end else begin
      $display("tb_websocket_frame_deframer: done, errors");
    end
    $finish;
  end

endmodule
